// ----- sv/icsm_pkg.sv -----
package icsm_pkg;

  localparam logic [15:0] PORT_CMD   = 16'h00C0;
  localparam logic [15:0] PORT_DATA  = 16'h00C2;
  localparam int          NUM_LEVELS = 8;
  localparam int          LEVEL_W    = $clog2(NUM_LEVELS);

  // OCW2 command field for a non-specific end of interrupt
  localparam logic [2:0]  OCW2_NS_EOI = 3'b001;

  typedef enum logic [1:0] {
    ACT_PORT_WRITE = 2'd0,
    ACT_IRQ        = 2'd1,
    ACT_POLL       = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ICW2  = 3'd1,
    PH_ICW4  = 3'd2,
    PH_INIT  = 3'd4,
    PH_READY = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] port_address;
    logic [7:0]  write_data;
    logic [7:0]  irq_lines;
    logic        cpu_if;
  } item_t;

  typedef struct packed {
    logic        int_issued;
    logic [7:0]  vector;
    logic        mask_written;
    logic [7:0]  mask_value;
    logic        mode_error;
  } result_t;

endpackage

// ----- sv/interrupt_controller_single_mode.sv -----
// Reduced 8259A-style interrupt controller, single 8086 mode, no cascading.
// Input channel (item_valid / item_stall / item) carries one beat per event:
// a port write to the command or data address, a raising of irq lines, or an
// interrupt poll from the cpu. Every input beat produces exactly one result
// beat on the output channel (result_valid / result_stall / result).
// The state update and the result are computed from the accepted beat and
// the current registers; both are registered at the same edge. Throughput
// is one beat per cycle while the receiver does not stall; the work per
// beat is an 8-bit priority encoder plus a few byte-wide masks.
// A new beat is taken whenever the result register is empty or its beat is
// being taken in the same cycle, so while the receiver stalls a held result
// the input stalls too, and nothing is dropped.
// Reset (rst, synchronous) returns the controller to the uninitialised
// phase, clears mask, request and in-service registers and empties the
// result register. ICW1, ICW2 and ICW4 must then be written before masks,
// end-of-interrupt commands or polls take effect.
module interrupt_controller_single_mode (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  icsm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output icsm_pkg::result_t result
);
  import icsm_pkg::*;

  phase_t                 phase, phase_next;
  logic [4:0]             vector_base, vector_base_next;
  logic                   auto_eoi, auto_eoi_next;
  logic [NUM_LEVELS-1:0]  mask_reg, mask_reg_next;
  logic [NUM_LEVELS-1:0]  request_reg, request_reg_next;
  logic [NUM_LEVELS-1:0]  in_service_reg, in_service_reg_next;
  logic                   last_level_valid, last_level_valid_next;
  logic [LEVEL_W-1:0]     last_level, last_level_next;
  result_t                result_next;

  logic                   accept;
  logic                   wr_hit, a0, icw1_ok, icw4_ok, eoi_cmd, poll_go;
  logic [LEVEL_W-1:0]     lvl;
  logic [NUM_LEVELS-1:0]  lvl_bit;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  assign wr_hit  = (item.action == ACT_PORT_WRITE) &&
                   ((item.port_address == PORT_CMD) || (item.port_address == PORT_DATA));
  assign a0      = (item.port_address == PORT_DATA);
  assign icw1_ok = ~a0 & item.write_data[4] & item.write_data[1] & item.write_data[0];
  assign icw4_ok = item.write_data[0] && (item.write_data[7:3] == 5'd0);
  assign eoi_cmd = (item.write_data[4:3] == 2'b00) && (item.write_data[7:5] == OCW2_NS_EOI);
  assign poll_go = (item.action == ACT_POLL) && (phase == PH_READY) && item.cpu_if &&
                   (request_reg != '0);

  // lowest pending level wins
  always_comb begin
    lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (request_reg[i]) begin
        lvl = LEVEL_W'(i);
      end
    end
  end
  assign lvl_bit = NUM_LEVELS'(1) << lvl;

  // initialisation sequence
  always_comb begin
    phase_next = phase;
    if (wr_hit) begin
      if (phase == PH_INIT) begin
        phase_next = PH_READY;
      end
      if (icw1_ok) begin
        phase_next = PH_ICW2;
      end else if (a0) begin
        case (phase)
          PH_ICW2: phase_next = PH_ICW4;
          PH_ICW4: if (icw4_ok) phase_next = PH_INIT;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    vector_base_next      = vector_base;
    auto_eoi_next         = auto_eoi;
    mask_reg_next         = mask_reg;
    request_reg_next      = request_reg;
    in_service_reg_next   = in_service_reg;
    last_level_valid_next = last_level_valid;
    last_level_next       = last_level;
    result_next           = '0;
    case (item.action)
      ACT_PORT_WRITE: begin
        if (wr_hit && a0 && phase == PH_ICW2) begin
          vector_base_next = item.write_data[7:3];
        end
        if (wr_hit && a0 && phase == PH_ICW4) begin
          auto_eoi_next          = item.write_data[1];
          result_next.mode_error = ~icw4_ok;
        end
        if (wr_hit && phase_next == PH_READY) begin
          if (a0) begin
            mask_reg_next            = item.write_data;
            result_next.mask_written = 1'b1;
            result_next.mask_value   = item.write_data;
          end else if (eoi_cmd && last_level_valid) begin
            in_service_reg_next = in_service_reg & ~(NUM_LEVELS'(1) << last_level);
          end
        end
      end
      ACT_IRQ: begin
        request_reg_next = (request_reg | item.irq_lines) & ~mask_reg;
      end
      ACT_POLL: begin
        if (poll_go) begin
          // a level already in service is consumed without a vector
          if (!(|(in_service_reg & lvl_bit))) begin
            result_next.int_issued = 1'b1;
            result_next.vector     = {vector_base, lvl};
          end
          request_reg_next      = request_reg & ~lvl_bit;
          in_service_reg_next   = auto_eoi ? (in_service_reg & ~lvl_bit)
                                           : (in_service_reg | lvl_bit);
          last_level_next       = lvl;
          last_level_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      vector_base      <= '0;
      auto_eoi         <= 1'b0;
      mask_reg         <= '0;
      request_reg      <= '0;
      in_service_reg   <= '0;
      last_level_valid <= 1'b0;
      last_level       <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        vector_base      <= vector_base_next;
        auto_eoi         <= auto_eoi_next;
        mask_reg         <= mask_reg_next;
        request_reg      <= request_reg_next;
        in_service_reg   <= in_service_reg_next;
        last_level_valid <= last_level_valid_next;
        last_level       <= last_level_next;
        result_valid     <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/icsm_checker.sv -----
module icsm_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input icsm_pkg::result_t result
);
  import icsm_pkg::*;

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present after reset");

  // every accepted item leaves a result beat behind
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted item gave no result beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // at most one kind of event per beat
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.int_issued, result.mask_written, result.mode_error}))
    else $error("result beat carries more than one event");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.int_issued || result.vector == '0) &&
                     (result.mask_written || result.mask_value == '0))
    else $error("payload byte set without its flag");

endmodule

bind interrupt_controller_single_mode icsm_checker u_icsm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
